// ===== design/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdc_pkg: shared types, constants and calendar helpers
// Item and result records, the Gregorian leap rule and the cumulative
// month tables used by the day counter and its sequencer.
// ----------------------------------------------------------------------------
package gdc_pkg;

  localparam int unsigned COUNT_W = 22;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned WYD_W   = 23;   // whole-year days, up to about 6.13M
  localparam int unsigned WYD_N_W = 15;   // whole-year index, up to 16782
  localparam int unsigned DOY_W   = 9;

  localparam logic [COUNT_W-1:0] MAX_COUNT  = 22'd3067671;  // 31 Dec 9999
  localparam logic [YEAR_W-1:0]  BASE_YEAR  = 14'd1601;
  localparam logic [YEAR_W-1:0]  YEAR_SHIFT = 14'd399;      // 2000 - 1601
  localparam logic [WYD_W-1:0]   WYD_BASE   = 23'd730485;   // days in 2000 years
  localparam logic [3:0]         MONTH_FIRST = 4'd2;
  localparam logic [3:0]         MONTH_LAST  = 4'd12;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [4:0]                day;
    logic [3:0]                month;
    logic [YEAR_W-1:0]         year;
    logic signed [COUNT_W-1:0] delta;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_number;
    logic [4:0]         out_day;
    logic [3:0]         out_month;
    logic [YEAR_W-1:0]  out_year;
    logic               range_flag;
  } result_t;

  // Leap rule: year mod 25 by reciprocal multiply, valid below 43690
  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [26:0]       prod;
    logic [YEAR_W-1:0] q25;
    logic [YEAR_W-1:0] r25;
    logic              by4;
    logic              by16;
    prod = 27'(year) * 27'(13'd5243);
    q25  = YEAR_W'(prod[26:17]);
    r25  = year - YEAR_W'((q25 << 4) + (q25 << 3) + q25);
    by4  = (year[1:0] == 2'b00);
    by16 = (year[3:0] == 4'b0000);
    return (by4 && (r25 != '0)) || (by16 && (r25 == '0));
  endfunction

  // Days before the first of month m; months above December use December
  function automatic logic [DOY_W-1:0] cum_days(input logic leap, input logic [3:0] m);
    logic [DOY_W-1:0] d;
    unique case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:  d = 9'd31;
      4'd3:  d = 9'd59;
      4'd4:  d = 9'd90;
      4'd5:  d = 9'd120;
      4'd6:  d = 9'd151;
      4'd7:  d = 9'd181;
      4'd8:  d = 9'd212;
      4'd9:  d = 9'd243;
      4'd10: d = 9'd273;
      4'd11: d = 9'd304;
      default: d = 9'd334;
    endcase
    if (leap && (m >= 4'd3)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// ===== design/gdc_wyd.sv =====
// ----------------------------------------------------------------------------
// gdc_wyd: whole-year day unit
// Registered count of days in the first n Gregorian years:
// n*365 + n/4 - n/100 + n/400, divisions by reciprocal multiply.
// ----------------------------------------------------------------------------
module gdc_wyd (
  input  logic                        clk,
  input  logic [gdc_pkg::WYD_N_W-1:0] n,
  output logic [gdc_pkg::WYD_W-1:0]   days
);

  logic [12:0] n4;
  logic [10:0] n16;
  logic [25:0] p100;
  logic [23:0] p400;
  logic [7:0]  q100;
  logic [5:0]  q400;
  logic [gdc_pkg::WYD_W-1:0] days_next;

  assign n4   = n[14:2];
  assign n16  = n[14:4];
  // x/25 = (x*5243) >> 17 holds well past these ranges
  assign p100 = 26'(n4) * 26'(13'd5243);
  assign p400 = 24'(n16) * 24'(13'd5243);
  assign q100 = 8'(p100[25:17]);
  assign q400 = 6'(p400[23:17]);

  assign days_next = (23'(n) << 8) + (23'(n) << 6) + (23'(n) << 5) + (23'(n) << 3)
                   + (23'(n) << 2) + 23'(n)
                   + 23'(n4) - 23'(q100) + 23'(q400);

  always_ff @(posedge clk) begin
    days <= days_next;
  end

endmodule

// ===== design/gdc_core.sv =====
// ----------------------------------------------------------------------------
// gdc_core: day counter sequencer
// Updates the stored day count, then walks the year estimate down with the
// shared whole-year unit and searches the month table one entry a cycle.
// ----------------------------------------------------------------------------
module gdc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gdc_pkg::item_t   item,
  input  logic             take,
  output logic             idle,
  output logic             done,
  output gdc_pkg::result_t result
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WHOLE = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_EST   = 8'b0000_1000,
    S_YEAR  = 8'b0001_0000,
    S_CHECK = 8'b0010_0000,
    S_MONTH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                          state;
  gdc_pkg::item_t                  item_r;
  logic [gdc_pkg::COUNT_W-1:0]     day_count;
  logic                            flag;
  logic                            leap_r;
  logic [gdc_pkg::YEAR_W-1:0]      y;
  logic [gdc_pkg::DOY_W-1:0]       doy;
  logic [3:0]                      m;

  logic [gdc_pkg::WYD_N_W-1:0]     wyd_n;
  logic [gdc_pkg::WYD_W-1:0]       wyd_q;

  logic [gdc_pkg::DOY_W-1:0]       tab_item;
  logic [gdc_pkg::DOY_W-1:0]       tab_m;
  logic signed [24:0]              sum_load;
  logic signed [24:0]              sum_add;
  logic signed [24:0]              next_val;
  logic [33:0]                     est_prod;
  logic [gdc_pkg::YEAR_W-1:0]      year_out;
  logic [gdc_pkg::WYD_W-1:0]       diff;
  logic                            over;

  gdc_wyd u_wyd (
    .clk  (clk),
    .n    (wyd_n),
    .days (wyd_q)
  );

  // Shared unit input: shifted load year first, then the year candidate
  assign wyd_n = (state == S_WHOLE) ? 15'(item_r.year) + 15'(gdc_pkg::YEAR_SHIFT)
                                    : 15'(y);

  assign tab_item = gdc_pkg::cum_days(leap_r, item_r.month);
  assign tab_m    = gdc_pkg::cum_days(leap_r, m);
  assign sum_load = $signed({2'b00, wyd_q}) - $signed({2'b00, gdc_pkg::WYD_BASE})
                  + $signed({16'b0, tab_item}) + $signed({20'b0, item_r.day});
  assign sum_add  = $signed({3'b000, day_count})
                  + $signed({{3{item_r.delta[21]}}, item_r.delta});
  assign next_val = (item_r.action == gdc_pkg::ACT_ADD) ? sum_add : sum_load;
  // Overestimate of count/365; the downward walk removes the excess
  assign est_prod = 34'(day_count) * 34'(12'd2873);
  assign year_out = gdc_pkg::BASE_YEAR + y;
  assign diff     = {1'b0, day_count} - wyd_q;
  assign over     = (wyd_q >= {1'b0, day_count}) && (y != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      day_count <= 22'd1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_r <= item;
            state  <= S_WHOLE;
          end
        end
        S_WHOLE: begin
          leap_r <= gdc_pkg::is_leap(item_r.year);
          state  <= S_SUM;
        end
        S_SUM: begin
          if (next_val < 25'sd1) begin
            day_count <= 22'd1;
            flag      <= 1'b1;
          end else if (next_val > $signed({3'b000, gdc_pkg::MAX_COUNT})) begin
            day_count <= gdc_pkg::MAX_COUNT;
            flag      <= 1'b1;
          end else begin
            day_count <= next_val[21:0];
            flag      <= 1'b0;
          end
          state <= S_EST;
        end
        S_EST: begin
          y     <= est_prod[33:20];
          state <= S_YEAR;
        end
        S_YEAR: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (over) begin
            y     <= y - 14'd1;
            state <= S_YEAR;
          end else begin
            doy    <= diff[8:0];
            leap_r <= gdc_pkg::is_leap(year_out);
            m      <= gdc_pkg::MONTH_FIRST;
            state  <= S_MONTH;
          end
        end
        S_MONTH: begin
          if ((m <= gdc_pkg::MONTH_LAST) && (doy > tab_m)) begin
            m <= m + 4'd1;
          end else begin
            m     <= m - 4'd1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    result.day_number = day_count;
    result.out_day    = 5'(doy - tab_m);
    result.out_month  = m;
    result.out_year   = year_out;
    result.range_flag = flag;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (day_count >= 22'd1) && (day_count <= gdc_pkg::MAX_COUNT))
    else $error("day count left the supported range");

  a_doy_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MONTH) |-> (doy >= 9'd1) && (doy <= 9'd366))
    else $error("day of year out of range after year walk");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_day >= 5'd1) && (result.out_month >= 4'd1)
             && (result.out_month <= gdc_pkg::MONTH_LAST))
    else $error("decoded date out of range");

  a_flag_limit: assert property (@(posedge clk) disable iff (rst)
    (done && flag) |-> (day_count == 22'd1) || (day_count == gdc_pkg::MAX_COUNT))
    else $error("range flag set away from a limit");

endmodule

// ===== design/gregorian_day_count_converter.sv =====
// ----------------------------------------------------------------------------
// gregorian_day_count_converter: Gregorian day counter
// Keeps a day count (day 1 = 1 Jan 1601), loads it from a date or adds a
// signed offset, and returns the count with the date it stands for.
//
//   channel  dir  tdata fields (low bit up)                 tuser
//   s_*      in   in_day, in_month, in_year, delta_days     action
//   m_*      out  day_number, out_day, out_month, out_year  range_flag
//
// An item goes from transfer to result through the load or add sum, the year
// estimate, a downward walk over the year candidates that the whole-year unit
// checks, and a month-table search. A new item is taken only once the last
// result has left the sequencer. Reset leaves the count at 1 (1 Jan 1601);
// s_tready is high only when idle. A held result keeps the sequencer in its
// done state, so s_tready stays low until that result transfers out.
// ----------------------------------------------------------------------------
module gregorian_day_count_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // in_day[4:0], in_month[8:5], in_year[22:9], delta_days[44:23]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // day_number[21:0], out_day[26:22], out_month[30:27],
                                 // out_year[44:31]
  output logic        m_tuser    // range_flag
);

  gdc_pkg::item_t   item;
  gdc_pkg::result_t result;
  logic             idle;
  logic             done;
  logic             start;
  logic             out_free;

  assign item.action = s_tuser;
  assign item.day    = s_tdata[4:0];
  assign item.month  = s_tdata[8:5];
  assign item.year   = s_tdata[22:9];
  assign item.delta  = s_tdata[44:23];

  assign s_tready = idle;
  assign start    = s_tvalid && idle;
  assign out_free = !m_tvalid || m_tready;

  gdc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .take   (out_free),
    .idle   (idle),
    .done   (done),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the output register when the sequencer hands over a result
  always_ff @(posedge clk) begin
    if (done && out_free) begin
      m_tdata <= {3'b000, result.out_year, result.out_month, result.out_day,
                  result.day_number};
      m_tuser <= result.range_flag;
    end
  end

endmodule

// ===== tb/gregorian_day_count_converter_tb.sv =====
// ----------------------------------------------------------------------------
// gregorian_day_count_converter_tb: self-checking bench for the day counter
// Drives load and add items through the input stream and compares every
// returned count, date and range flag with a local calendar tracker. Both
// sides idle at random, with idle-free stretches and long output holds.
// ----------------------------------------------------------------------------
module gregorian_day_count_converter_tb;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // in_day, in_month, in_year, delta_days
  logic        s_tuser = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // day_number, out_day, out_month, out_year
  logic        m_tuser;        // range_flag

  int cycles   = 0;
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  gregorian_day_count_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Tracks the stored count and queues the count and date each item returns
  class day_count_tracker;
    longint unsigned  month_start[13];
    longint           count;
    gdc_pkg::result_t expected_dates[$];
    int               errors;

    function new();
      month_start = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      count  = 1;
      errors = 0;
    endfunction

    function bit leap_year(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function longint whole_year_days(longint n);
      return n * 365 + n / 4 - n / 100 + n / 400;
    endfunction

    function longint days_before_month(bit leap, int unsigned m);
      return month_start[m] + ((leap && m >= 3) ? 1 : 0);
    endfunction

    function void note_item(gdc_pkg::item_t it);
      longint           nxt;
      longint           yrs;
      longint           prior;
      longint           doy;
      longint           yr;
      int unsigned      mo;
      bit               clipped;
      bit               leap;
      gdc_pkg::result_t r;
      if (it.action == gdc_pkg::ACT_LOAD) begin
        yr  = longint'(it.year);
        mo  = (it.month > 4'd12) ? 12 : int'(it.month);
        // shift by 399 years so the floor division stays on non-negative indexes
        nxt = whole_year_days(yr + 399) - whole_year_days(2000)
            + days_before_month(leap_year(yr), mo) + longint'(it.day);
      end else begin
        nxt = count + longint'($signed(it.delta));
      end
      clipped = 1'b0;
      if (nxt < 1) begin
        nxt = 1;
        clipped = 1'b1;
      end else if (nxt > longint'(gdc_pkg::MAX_COUNT)) begin
        nxt = longint'(gdc_pkg::MAX_COUNT);
        clipped = 1'b1;
      end
      count = nxt;

      // estimate the year, then step down until whole years fall below count
      yrs   = count / 365;
      prior = whole_year_days(yrs);
      while (prior >= count && yrs > 0) begin
        yrs--;
        prior = whole_year_days(yrs);
      end
      yr   = 1601 + yrs;
      doy  = count - prior;
      leap = leap_year(yr);
      mo   = 2;
      while (mo <= 12 && doy > days_before_month(leap, mo)) mo++;
      mo--;
      r.day_number = count[21:0];
      r.out_day    = 5'(doy - days_before_month(leap, mo));
      r.out_month  = 4'(mo);
      r.out_year   = yr[13:0];
      r.range_flag = clipped;
      expected_dates.push_back(r);
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [47:0] data, logic flag);
      gdc_pkg::result_t e;
      if (expected_dates.size() == 0) begin
        $display("%0t: result with none pending, expected none actual count %0d",
                 $time, data[21:0]);
        errors++;
        return;
      end
      e = expected_dates.pop_front();
      compare_field("day_number", e.day_number, data[21:0]);
      compare_field("out_day",    e.out_day,    data[26:22]);
      compare_field("out_month",  e.out_month,  data[30:27]);
      compare_field("out_year",   e.out_year,   data[44:31]);
      compare_field("range_flag", e.range_flag, flag);
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  day_count_tracker tracker = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("gregorian_day_count_converter_tb failed");
      $finish;
    end
  end

  function automatic gdc_pkg::item_t load_item(int d, int m, int y);
    gdc_pkg::item_t it;
    it        = '0;
    it.action = gdc_pkg::ACT_LOAD;
    it.day    = 5'(d);
    it.month  = 4'(m);
    it.year   = 14'(y);
    it.delta  = 22'($urandom);
    return it;
  endfunction

  function automatic gdc_pkg::item_t add_item(longint d);
    gdc_pkg::item_t it;
    it        = '0;
    it.action = gdc_pkg::ACT_ADD;
    it.day    = 5'($urandom);
    it.month  = 4'($urandom);
    it.year   = 14'($urandom);
    it.delta  = 22'(d);
    return it;
  endfunction

  function automatic gdc_pkg::item_t random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return load_item(($urandom_range(0, 1) != 0) ? $urandom_range(1, 28) : $urandom_range(1, 31),
                       $urandom_range(1, 12), $urandom_range(1601, 9999));
    end else if (pick < 85) begin
      return add_item(longint'(int'($urandom_range(0, 4000)) - 2000));
    end else if (pick < 95) begin
      return add_item(longint'($signed(22'($urandom))));
    end
    // raw fields: day zero, months past December, years out of range
    return load_item($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
  endfunction

  // Hold valid high across back-to-back items; lower it only before a gap
  task automatic send_item(input gdc_pkg::item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, it.delta, it.year, it.month, it.day};
    s_tuser  <= it.action;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_item(it);
  endtask

  initial begin : results
    int wait_n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        wait_n   = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        wait_n = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      tracker.check_result(m_tdata, m_tuser);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(load_item(1, 1, 1601));
    send_item(load_item(31, 12, 9999));
    send_item(add_item(0));
    send_item(add_item(1));                 // past the top: saturate
    send_item(add_item(-2097152));
    send_item(add_item(2097151));
    send_item(load_item(29, 2, 2000));
    send_item(load_item(29, 2, 1900));      // not a leap year: rolls into March
    send_item(load_item(1, 3, 2100));
    send_item(load_item(31, 12, 2000));
    send_item(load_item(0, 1, 1602));       // day zero: last day of prior year
    send_item(load_item(31, 2, 2023));
    send_item(load_item(15, 0, 2024));      // month zero acts as January
    send_item(load_item(31, 15, 2024));     // months past 12 use December
    send_item(load_item(31, 12, 1600));     // before the epoch: saturate low
    send_item(load_item(1, 1, 0));
    send_item(load_item(31, 15, 16383));    // far past 9999: saturate high
    send_item(load_item(1, 1, 10000));
    send_item(load_item(1, 1, 1601));
    send_item(add_item(-1));                // below day one: saturate
    send_item(add_item(-2097152));
    send_item(add_item(365));
    send_item(add_item(1460));
    send_item(add_item(2097151));
    send_item(load_item(28, 2, 1700));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 250 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == 400 || i == 1100) hold_req = 1'b1;
      send_item(random_item());
    end
    s_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("gregorian_day_count_converter_tb passed");
    end else begin
      $display("gregorian_day_count_converter_tb failed");
    end
    $finish;
  end

endmodule
